>>> hw/rtl/counting_sort_small_range_unit_defines.svh
// assertion macros shared by the counting sort block
`ifndef COUNTING_SORT_SMALL_RANGE_UNIT_DEFINES_SVH
`define COUNTING_SORT_SMALL_RANGE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CSSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cssr check failed");

// next-cycle implication, checked out of reset
`define CSSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cssr check failed");

`endif

>>> hw/rtl/cssr_pkg.sv
// shared constants for the counting sort block
package cssr_pkg;
    localparam int VAL_W         = 7;
    localparam int DEF_NUM_BINS  = 128;
    localparam int DEF_MAX_ITEMS = 64;
endpackage

>>> hw/rtl/counting_sort_small_range_unit.sv
// counting sort top level: histogram memory, increment pipeline and walk sequencer
//
// input channel i_valid/o_ready carries i_value and i_last; output channel
// o_valid/i_ready carries o_sorted_value and o_last_res.
// after reset the histogram memory is swept to zero, one bin per cycle, and
// o_ready stays low during the sweep.
// while a set loads, one value is taken every cycle: a registered read of the
// histogram memory and a write back in the next cycle, with the just-written
// count forwarded when two neighboring values hit the same bin.
// values past MAX_ITEMS in a set and values not below NUM_BINS are dropped.
// on the request marked last, o_ready drops and the bins are walked from
// zero up: after a flush step each bin is read, its count is captured and an
// empty bin moves the walk on to the next; results of one bin follow one per
// cycle while the receiver takes them, and once a bin is drained the walk
// goes on to read the next bin.
// the walk zeroes each bin it drains and stops on the final result, which
// carries o_last_res; o_ready then rises again. an empty set gives no result.
// a stalled receiver holds the output register and the walk waits for it.
module counting_sort_small_range_unit #(
    parameter int NUM_BINS  = cssr_pkg::DEF_NUM_BINS,
    parameter int MAX_ITEMS = cssr_pkg::DEF_MAX_ITEMS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [cssr_pkg::VAL_W-1:0] i_value,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [cssr_pkg::VAL_W-1:0] o_sorted_value,
    output logic                       o_last_res
);
    import cssr_pkg::*;

    `include "counting_sort_small_range_unit_defines.svh"

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic             take;
    logic [CNT_W-1:0] rd_data;
    logic             acc_re;
    logic [BIN_W-1:0] acc_raddr;
    logic             acc_we;
    logic [BIN_W-1:0] acc_waddr;
    logic [CNT_W-1:0] acc_wdata;
    logic             ctl_re;
    logic             ctl_we;
    logic [BIN_W-1:0] ctl_addr;
    logic             mem_we;
    logic [BIN_W-1:0] mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic             mem_re;
    logic [BIN_W-1:0] mem_raddr;
    logic             more_res;

    cssr_ctrl #(
        .NUM_BINS  (NUM_BINS),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_last_res     (o_last_res),
        .o_take         (take),
        .i_rd_data      (rd_data),
        .o_re           (ctl_re),
        .o_we           (ctl_we),
        .o_addr         (ctl_addr)
    );

    cssr_accum #(
        .NUM_BINS  (NUM_BINS),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_value   (i_value),
        .i_rd_data (rd_data),
        .o_re      (acc_re),
        .o_raddr   (acc_raddr),
        .o_we      (acc_we),
        .o_waddr   (acc_waddr),
        .o_wdata   (acc_wdata)
    );

    // loading and walking never overlap, so the ports are shared by selection
    assign mem_we    = acc_we || ctl_we;
    assign mem_waddr = acc_we ? acc_waddr : ctl_addr;
    assign mem_wdata = acc_we ? acc_wdata : '0;
    assign mem_re    = acc_re || ctl_re;
    assign mem_raddr = acc_re ? acc_raddr : ctl_addr;

    cssr_ram #(
        .DEPTH (NUM_BINS),
        .WIDTH (CNT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // a result of the set was taken and more of the same set follow
    assign more_res = o_valid && i_ready && !o_last_res;

    `CSSR_ASSERT_NOW(a_no_write_clash, acc_we, !ctl_we)
    `CSSR_ASSERT_NOW(a_no_read_clash, acc_re, !ctl_re)
    `CSSR_ASSERT_NEXT(a_ascending, more_res, !o_valid || (o_sorted_value >= $past(o_sorted_value)))
endmodule

>>> hw/rtl/cssr_ram.sv
// histogram memory: one write port, one read port with registered data
module cssr_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 7
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/cssr_accum.sv
// histogram increment pipeline: read, add one, write back with forwarding
module cssr_accum #(
    parameter int NUM_BINS  = cssr_pkg::DEF_NUM_BINS,
    parameter int MAX_ITEMS = cssr_pkg::DEF_MAX_ITEMS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_take,
    input  logic [cssr_pkg::VAL_W-1:0]           i_value,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]       i_rd_data,
    output logic                                 o_re,
    output logic [$clog2(NUM_BINS)-1:0]          o_raddr,
    output logic                                 o_we,
    output logic [$clog2(NUM_BINS)-1:0]          o_waddr,
    output logic [$clog2(MAX_ITEMS+1)-1:0]       o_wdata
);
    import cssr_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic             r_s1_vld;
    logic [BIN_W-1:0] r_s1_addr;
    logic             r_wb_vld;
    logic [BIN_W-1:0] r_wb_addr;
    logic [CNT_W-1:0] r_wb_cnt;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] n_cnt;

    assign o_re    = i_take;
    assign o_raddr = BIN_W'(i_value);

    // the previous write lands on the same edge as this read, so take it from the register
    always_comb begin
        if (r_wb_vld && (r_wb_addr == r_s1_addr)) begin
            base = r_wb_cnt;
        end else begin
            base = i_rd_data;
        end
        n_cnt = base + CNT_W'(1);
    end

    assign o_we    = r_s1_vld;
    assign o_waddr = r_s1_addr;
    assign o_wdata = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_wb_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_take;
            r_wb_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= BIN_W'(i_value);
        r_wb_addr <= r_s1_addr;
        r_wb_cnt  <= n_cnt;
    end
endmodule

>>> hw/rtl/cssr_ctrl.sv
// sequencer: reset clearing pass, input admission, bin walk and output register
module cssr_ctrl #(
    parameter int NUM_BINS  = cssr_pkg::DEF_NUM_BINS,
    parameter int MAX_ITEMS = cssr_pkg::DEF_MAX_ITEMS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [cssr_pkg::VAL_W-1:0]           i_value,
    input  logic                                 i_last,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [cssr_pkg::VAL_W-1:0]           o_sorted_value,
    output logic                                 o_last_res,
    output logic                                 o_take,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]       i_rd_data,
    output logic                                 o_re,
    output logic                                 o_we,
    output logic [$clog2(NUM_BINS)-1:0]          o_addr
);
    import cssr_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_CNT   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]       r_state,   n_state;
    logic [BIN_W-1:0] r_ptr,     n_ptr;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic [CNT_W-1:0] r_taken,   n_taken;
    logic [CNT_W-1:0] r_emitted, n_emitted;
    logic             r_out_vld, n_out_vld;
    logic [VAL_W-1:0] r_out_val, n_out_val;
    logic             r_out_last, n_out_last;

    logic accept;
    logic in_range;
    logic room;
    logic fire;
    logic final_one;

    assign o_ready   = (r_state == ST_LOAD);
    assign accept    = i_valid && o_ready;
    assign in_range  = (32'(i_value) < NUM_BINS);
    assign room      = (32'(r_taken) < MAX_ITEMS);
    assign o_take    = accept && in_range && room;
    assign fire      = !r_out_vld || i_ready;
    assign final_one = ((r_emitted + CNT_W'(1)) == r_taken);
    assign o_addr    = r_ptr;

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_cnt      = r_cnt;
        n_taken    = r_taken;
        n_emitted  = r_emitted;
        n_out_vld  = r_out_vld && !i_ready;
        n_out_val  = r_out_val;
        n_out_last = r_out_last;
        o_re       = 1'b0;
        o_we       = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_we = 1'b1;
                if (r_ptr == BIN_W'(NUM_BINS - 1)) begin
                    n_ptr   = '0;
                    n_state = ST_LOAD;
                end else begin
                    n_ptr = r_ptr + BIN_W'(1);
                end
            end
            ST_LOAD: begin
                if (o_take) begin
                    n_taken = r_taken + CNT_W'(1);
                end
                if (accept && i_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // the increment of the last request, if it was taken, is written this cycle
                if (r_taken == '0) begin
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                o_re    = 1'b1;
                n_state = ST_CNT;
            end
            ST_CNT: begin
                n_cnt = i_rd_data;
                if (i_rd_data == '0) begin
                    n_ptr   = r_ptr + BIN_W'(1);
                    n_state = ST_RD;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (fire) begin
                    n_out_vld  = 1'b1;
                    n_out_val  = VAL_W'(r_ptr);
                    n_out_last = final_one;
                    n_emitted  = r_emitted + CNT_W'(1);
                    n_cnt      = r_cnt - CNT_W'(1);
                    if (final_one) begin
                        // bins past this one are already zero
                        o_we      = 1'b1;
                        n_ptr     = '0;
                        n_taken   = '0;
                        n_emitted = '0;
                        n_state   = ST_LOAD;
                    end else if (r_cnt == CNT_W'(1)) begin
                        o_we    = 1'b1;
                        n_ptr   = r_ptr + BIN_W'(1);
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_ptr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_ptr     <= '0;
            r_taken   <= '0;
            r_emitted <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_taken   <= n_taken;
            r_emitted <= n_emitted;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
    end

    assign o_valid        = r_out_vld;
    assign o_sorted_value = r_out_val;
    assign o_last_res     = r_out_last;
endmodule
